FILE: rtl/h264rr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP frame reassembler package
// Shared sizes, command and packet kind codes, and the result record.
// ----------------------------------------------------------------------------
package h264rr_pkg;

   localparam int BUF_SIZE = 65536;
   localparam int AW       = $clog2(BUF_SIZE);
   localparam int SW       = ((AW > 16) ? AW : 16) + 2;
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PW    = $clog2(RQ_DEPTH);

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_ABORT = 2'd2;

   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_FRAG   = 2'd1;
   localparam logic [1:0] KIND_AGGR   = 2'd2;

   typedef struct packed {
      logic        frame_ready;
      logic [15:0] frame_length;
      logic [7:0]  read_data;
      logic        dropped;
   } rsp_type;

endpackage

FILE: rtl/h264rr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP frame reassembler request channel
// Valid/ready channel that carries one payload byte, read or abort request.
// ----------------------------------------------------------------------------
interface h264rr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [1:0]  packet_kind;
   logic        start_flag;
   logic        end_flag;
   logic        first_byte;
   logic        last_byte;
   logic [15:0] packet_length;
   logic [7:0]  data_byte;
   logic [7:0]  nal_header_byte;
   logic        nal_header_length;
   logic [15:0] read_address;

   modport source (
      output valid, command, packet_kind, start_flag, end_flag, first_byte, last_byte,
             packet_length, data_byte, nal_header_byte, nal_header_length, read_address,
      input  ready
   );

   modport sink (
      input  valid, command, packet_kind, start_flag, end_flag, first_byte, last_byte,
             packet_length, data_byte, nal_header_byte, nal_header_length, read_address,
      output ready
   );
endinterface

FILE: rtl/h264rr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP frame reassembler response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface h264rr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ready;
   logic [15:0] frame_length;
   logic [7:0]  read_data;
   logic        dropped;

   modport source (
      output valid, frame_ready, frame_length, read_data, dropped,
      input  ready
   );

   modport sink (
      input  valid, frame_ready, frame_length, read_data, dropped,
      output ready
   );
endinterface

FILE: rtl/h264_rtp_frame_reassembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP frame reassembler
// Rebuilds Annex B frames from parsed RTP payload bytes in a frame store.
// ----------------------------------------------------------------------------
//   channel   direction   handshake      payload
//   req_ch    in          valid/ready    command, packet fields, byte, address
//   rsp_ch    out         valid/ready    frame_ready, frame_length, read_data, dropped
//
// A read or an abort writes nothing to the store. The first byte of a packet
// that gets a start code (and a NAL header) makes one store write per byte,
// five or six in all, since the store has a single write port; req_ch stalls meanwhile.
// A result is registered with the store's read data, then queued before it reaches rsp_ch.
// Four results fit in the result stage and queue; req_ch stalls while they hold all four.
// Reset clears the control state; the frame store contents are not cleared.
module h264_rtp_frame_reassembler_unit (
   input logic        clock,
   input logic        reset,
   h264rr_req_if.sink   req_ch,
   h264rr_rsp_if.source rsp_ch
);

   import h264rr_pkg::*;

   function automatic logic [7:0] seq_byte(input logic [2:0] idx, input logic [2:0] pre,
                                           input logic [7:0] hdr, input logic [7:0] dat);
      logic [7:0] b;
      b = dat;
      if (idx < pre) begin
         case (idx)
            3'd3:    b = 8'h01;
            3'd4:    b = hdr;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

   logic [AW-1:0]    fill_ff, fill_in;
   logic             asm_ff, asm_in;
   logic             acc_ff, acc_in;
   logic             clr_ff, clr_in;

   logic [2:0]       seq_cnt_ff, seq_cnt_in;
   logic [2:0]       seq_idx_ff, seq_idx_in;
   logic [2:0]       seq_pre_ff, seq_pre_in;
   logic [AW-1:0]    seq_addr_ff, seq_addr_in;
   logic [7:0]       seq_hdr_ff, seq_hdr_in;
   logic [7:0]       seq_dat_ff, seq_dat_in;

   logic             r1_v_ff;
   rsp_type          r1_res_ff, r1_res_in;
   logic             r1_rd_ff, r1_rd_in;

   rsp_type          rq_ff [RQ_DEPTH];
   logic [RQ_PW-1:0] head_ff, tail_ff;
   logic [RQ_PW:0]   cnt_ff;
   logic [RQ_PW:0]   occ;

   logic             accept, pop, push;
   logic             nonempty, chk, fits, ok, data_wr, deliver;
   logic [SW-1:0]    need;
   logic [AW-1:0]    base, fill_p;
   logic [2:0]       prefix_n, n_wr;
   rsp_type          res;
   rsp_type          push_res;

   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;

   assign occ          = cnt_ff + (RQ_PW+1)'(r1_v_ff);
   assign req_ch.ready = (seq_cnt_ff == 3'd0) && (occ < (RQ_PW+1)'(RQ_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = rsp_ch.valid && rsp_ch.ready;
   assign push         = r1_v_ff;
   assign nonempty     = req_ch.packet_length != 16'd0;

   always_comb begin
      fill_in  = fill_ff;
      asm_in   = asm_ff;
      acc_in   = acc_ff;
      clr_in   = clr_ff;
      need     = '0;
      chk      = 1'b0;
      fits     = 1'b0;
      ok       = 1'b0;
      data_wr  = 1'b0;
      deliver  = 1'b0;
      prefix_n = 3'd0;
      base     = fill_ff;
      fill_p   = fill_ff;
      res      = '0;
      r1_rd_in = 1'b0;
      case (req_ch.command)
         CMD_PUSH: begin
            if (req_ch.first_byte || !nonempty) begin
               if (clr_in) begin
                  fill_in = '0;
                  clr_in  = 1'b0;
               end
               if (req_ch.packet_kind == KIND_SINGLE) begin
                  if (asm_in) begin
                     fill_in = '0;
                  end
                  asm_in = 1'b0;
               end
               case (req_ch.packet_kind)
                  KIND_SINGLE: need = SW'(req_ch.packet_length) + SW'(4);
                  KIND_FRAG:   need = SW'(req_ch.packet_length) + SW'(4)
                                      + SW'(req_ch.nal_header_length);
                  default:     need = SW'(req_ch.packet_length);
               endcase
               chk  = nonempty && (req_ch.packet_kind inside {KIND_SINGLE, KIND_FRAG,
                                                              KIND_AGGR});
               fits = (SW'(fill_in) + need) < SW'(BUF_SIZE);
               ok   = chk && fits;
               if (chk && !fits) begin
                  fill_in     = '0;
                  asm_in      = 1'b0;
                  res.dropped = 1'b1;
               end
               if (ok && req_ch.packet_kind == KIND_SINGLE) begin
                  prefix_n = 3'd4;
               end
               if (ok && req_ch.packet_kind == KIND_FRAG && req_ch.start_flag) begin
                  if (asm_in) begin
                     fill_in = '0;
                  end
                  asm_in   = 1'b1;
                  prefix_n = req_ch.nal_header_length ? 3'd5 : 3'd4;
               end
               acc_in = ok;
            end
            base    = fill_in;
            fill_p  = fill_in + AW'(prefix_n);
            fill_in = fill_p;
            if (acc_in && nonempty) begin
               data_wr = {1'b0, fill_p} < (AW+1)'(BUF_SIZE - 1);
               fill_in = fill_p + AW'(data_wr);
               if (req_ch.last_byte) begin
                  case (req_ch.packet_kind)
                     KIND_FRAG: begin
                        if (req_ch.end_flag) begin
                           asm_in  = 1'b0;
                           deliver = 1'b1;
                        end
                     end
                     KIND_SINGLE, KIND_AGGR: deliver = 1'b1;
                     default:                deliver = 1'b0;
                  endcase
                  if (deliver) begin
                     res.frame_ready  = 1'b1;
                     res.frame_length = 16'(fill_in);
                     clr_in           = 1'b1;
                  end
                  acc_in = 1'b0;
               end
            end
         end
         CMD_READ: begin
            r1_rd_in = {16'd0, req_ch.read_address} < 32'(BUF_SIZE);
         end
         CMD_ABORT: begin
            fill_in = '0;
            asm_in  = 1'b0;
            acc_in  = 1'b0;
            clr_in  = 1'b0;
         end
         default: begin
            res = '0;
         end
      endcase
      r1_res_in = res;
   end

   assign n_wr = prefix_n + 3'(data_wr);

   always_comb begin
      seq_cnt_in  = seq_cnt_ff;
      seq_idx_in  = seq_idx_ff;
      seq_addr_in = seq_addr_ff;
      seq_pre_in  = seq_pre_ff;
      seq_hdr_in  = seq_hdr_ff;
      seq_dat_in  = seq_dat_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = seq_addr_ff;
      ram_wr_data = seq_byte(seq_idx_ff, seq_pre_ff, seq_hdr_ff, seq_dat_ff);
      if (seq_cnt_ff != 3'd0) begin
         ram_wr_en   = 1'b1;
         seq_cnt_in  = seq_cnt_ff - 3'd1;
         seq_idx_in  = seq_idx_ff + 3'd1;
         seq_addr_in = seq_addr_ff + AW'(1);
      end else if (accept && n_wr != 3'd0) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = base;
         ram_wr_data = seq_byte(3'd0, prefix_n, req_ch.nal_header_byte, req_ch.data_byte);
         seq_cnt_in  = n_wr - 3'd1;
         seq_idx_in  = 3'd1;
         seq_addr_in = base + AW'(1);
         seq_pre_in  = prefix_n;
         seq_hdr_in  = req_ch.nal_header_byte;
         seq_dat_in  = req_ch.data_byte;
      end
   end

   assign ram_rd_en = accept && (req_ch.command == CMD_READ);

   h264rr_ram #(
      .WIDTH (8),
      .DEPTH (BUF_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (AW'(req_ch.read_address)),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      push_res           = r1_res_ff;
      push_res.read_data = r1_rd_ff ? ram_rd_data : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         asm_ff     <= 1'b0;
         acc_ff     <= 1'b0;
         clr_ff     <= 1'b0;
         seq_cnt_ff <= 3'd0;
         r1_v_ff    <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
            asm_ff  <= asm_in;
            acc_ff  <= acc_in;
            clr_ff  <= clr_in;
         end
         seq_cnt_ff <= seq_cnt_in;
         r1_v_ff    <= accept;
         if (push) begin
            tail_ff <= tail_ff + RQ_PW'(1);
         end
         if (pop) begin
            head_ff <= head_ff + RQ_PW'(1);
         end
         cnt_ff <= cnt_ff + (RQ_PW+1)'(push) - (RQ_PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      seq_idx_ff  <= seq_idx_in;
      seq_addr_ff <= seq_addr_in;
      seq_pre_ff  <= seq_pre_in;
      seq_hdr_ff  <= seq_hdr_in;
      seq_dat_ff  <= seq_dat_in;
      if (accept) begin
         r1_res_ff <= r1_res_in;
         r1_rd_ff  <= r1_rd_in;
      end
      if (push) begin
         rq_ff[tail_ff] <= push_res;
      end
   end

   assign rsp_ch.valid        = cnt_ff != '0;
   assign rsp_ch.frame_ready  = rq_ff[head_ff].frame_ready;
   assign rsp_ch.frame_length = rq_ff[head_ff].frame_length;
   assign rsp_ch.read_data    = rq_ff[head_ff].read_data;
   assign rsp_ch.dropped      = rq_ff[head_ff].dropped;

`ifndef ASSERT_OFF
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      r1_v_ff && (cnt_ff == (RQ_PW+1)'(RQ_DEPTH)) |-> pop)
      else $error("result queue overflow");

   a_write_seq_steps: assert property (@(posedge clock) disable iff (reset)
      seq_cnt_ff != 3'd0 |=> seq_cnt_ff == $past(seq_cnt_ff) - 3'd1)
      else $error("store write sequence did not advance by one");

   a_ready_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_ready |-> !rsp_ch.dropped)
      else $error("frame delivered on a dropped packet");
`endif

endmodule

FILE: rtl/h264rr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module h264rr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
